// ===== design/walsh_hadamard_transform_top_assert.svh =====
// Assertion macros used by the Walsh-Hadamard transform sequencer
`ifndef WALSH_HADAMARD_TRANSFORM_TOP_ASSERT_SVH
`define WALSH_HADAMARD_TRANSFORM_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define WHT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define WHT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/wht_pkg.sv =====
// Shared types and fixed constants of the Walsh-Hadamard transform
package wht_pkg;

	localparam int COEF_BITS   = 20;
	localparam int MUL_BITS    = 15;
	localparam int SCALE_MUL   = 11585;
	localparam int SCALE_SHIFT = 17;
	localparam int ROUND_BIAS  = 1 << (SCALE_SHIFT - 1);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_XFORM,
		ST_DRAIN,
		ST_EMIT_RD,
		ST_EMIT_MUL,
		ST_EMIT_OUT
	} wht_state_t;

	typedef struct packed {
		logic load_wr;
		logic bfly_wr;
		logic mul_en;
		logic out_load;
	} wht_ctrl_t;

endpackage

// ===== design/walsh_hadamard_transform_top.sv =====
// Top level of the 128-point fast Walsh-Hadamard transform with fixed-point scaling
//
//  channel | signals                                       | direction
//  --------+-----------------------------------------------+----------
//  sample  | sample_valid, sample_stall, sample             | in
//  pair    | pair_valid, pair_stall, pair_index, even_coef, | out
//          | odd_coef, last_pair                           |
//
// Load takes one item a cycle. The butterfly unit runs one butterfly a cycle over two
// store banks split by index parity, with a drain step after each stage.
// Output reads each pair, registers its products, then loads the output register.
// sample_stall is high after the last sample of a block until the last item is registered.
// pair_stall holds the output register; reset clears control only, the store is not cleared.
module walsh_hadamard_transform_top #(
	parameter int POINTS      = 128,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	output logic                                 pair_valid,
	input  logic                                 pair_stall,
	output logic [$clog2(POINTS)-2:0]            pair_index,
	output logic signed [wht_pkg::COEF_BITS-1:0] even_coef,
	output logic signed [wht_pkg::COEF_BITS-1:0] odd_coef,
	output logic                                 last_pair
);
	import wht_pkg::*;

	localparam int IDX_W   = $clog2(POINTS);
	localparam int ADDR_W  = IDX_W - 1;
	localparam int STORE_W = SAMPLE_BITS + IDX_W;

	wht_ctrl_t                ctrl;
	logic [IDX_W-1:0]         fill_idx, rd_a, rd_b, a_idx, b_idx;
	logic [ADDR_W-1:0]        raddr0, raddr1, waddr0, waddr1;
	logic [STORE_W-1:0]       rdata0, rdata1, wdata0, wdata1;
	logic                     we0, we1;
	logic                     a_hi;
	logic signed [STORE_W-1:0] a_val, b_val, sum, diff, ext_sample;

	wht_seq #(.IDX_W(IDX_W)) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.pair_valid   (pair_valid),
		.pair_stall   (pair_stall),
		.pair_index   (pair_index),
		.last_pair    (last_pair),
		.ctrl         (ctrl),
		.fill_idx     (fill_idx),
		.rd_a         (rd_a),
		.rd_b         (rd_b),
		.a_idx        (a_idx),
		.b_idx        (b_idx)
	);

	assign raddr0 = (^rd_a) ? rd_b[IDX_W-1:1] : rd_a[IDX_W-1:1];
	assign raddr1 = (^rd_a) ? rd_a[IDX_W-1:1] : rd_b[IDX_W-1:1];

	assign a_hi  = ^a_idx;
	assign a_val = a_hi ? rdata1 : rdata0;
	assign b_val = a_hi ? rdata0 : rdata1;
	assign sum   = a_val + b_val;
	assign diff  = a_val - b_val;

	assign ext_sample = STORE_W'(sample);

	always_comb begin
		if (ctrl.load_wr) begin
			we0    = !(^fill_idx);
			we1    = ^fill_idx;
			waddr0 = fill_idx[IDX_W-1:1];
			waddr1 = fill_idx[IDX_W-1:1];
			wdata0 = ext_sample;
			wdata1 = ext_sample;
		end else begin
			we0    = ctrl.bfly_wr;
			we1    = ctrl.bfly_wr;
			waddr0 = a_hi ? b_idx[IDX_W-1:1] : a_idx[IDX_W-1:1];
			waddr1 = a_hi ? a_idx[IDX_W-1:1] : b_idx[IDX_W-1:1];
			wdata0 = a_hi ? diff : sum;
			wdata1 = a_hi ? sum : diff;
		end
	end

	wht_bank #(.ADDR_W(ADDR_W), .DATA_W(STORE_W)) u_bank0 (
		.clk   (clk),
		.we    (we0),
		.waddr (waddr0),
		.wdata (wdata0),
		.raddr (raddr0),
		.rdata (rdata0)
	);

	wht_bank #(.ADDR_W(ADDR_W), .DATA_W(STORE_W)) u_bank1 (
		.clk   (clk),
		.we    (we1),
		.waddr (waddr1),
		.wdata (wdata1),
		.raddr (raddr1),
		.rdata (rdata1)
	);

	wht_scale #(.STORE_W(STORE_W)) u_scale_even (
		.clk      (clk),
		.mul_en   (ctrl.mul_en),
		.out_load (ctrl.out_load),
		.value    (a_val),
		.coef     (even_coef)
	);

	wht_scale #(.STORE_W(STORE_W)) u_scale_odd (
		.clk      (clk),
		.mul_en   (ctrl.mul_en),
		.out_load (ctrl.out_load),
		.value    (b_val),
		.coef     (odd_coef)
	);

endmodule

// ===== design/wht_bank.sv =====
// One bank of the sample store: one write port, one registered read port
module wht_bank #(
	parameter int ADDR_W = 6,
	parameter int DATA_W = 23
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/wht_scale.sv =====
// Orthonormal scaling of one coefficient: multiply, product register, round half up, output register
module wht_scale #(
	parameter int STORE_W = 23
) (
	input  logic                                 clk,
	input  logic                                 mul_en,
	input  logic                                 out_load,
	input  logic signed [STORE_W-1:0]            value,
	output logic signed [wht_pkg::COEF_BITS-1:0] coef
);
	import wht_pkg::*;

	localparam int PROD_W = STORE_W + MUL_BITS;
	localparam int EXT_W  = PROD_W + COEF_BITS;
	localparam logic signed [MUL_BITS-1:0] SCALE_K = MUL_BITS'(SCALE_MUL);

	logic signed [PROD_W-1:0]    prod;
	logic signed [PROD_W-1:0]    prod_q;
	logic signed [PROD_W-1:0]    rnd;
	logic signed [EXT_W-1:0]     ext;
	logic signed [COEF_BITS-1:0] coef_q;

	assign prod = value * SCALE_K;
	assign rnd  = (prod_q + PROD_W'(ROUND_BIAS)) >>> SCALE_SHIFT;
	assign ext  = EXT_W'(rnd);

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= prod;
		end
		if (out_load) begin
			coef_q <= ext[COEF_BITS-1:0];
		end
	end

	assign coef = coef_q;

endmodule

// ===== design/wht_seq.sv =====
// Sequencer: load count, butterfly stride and index generation, output pacing
`include "walsh_hadamard_transform_top_assert.svh"

module wht_seq #(
	parameter int IDX_W = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    sample_valid,
	output logic                    sample_stall,
	output logic                    pair_valid,
	input  logic                    pair_stall,
	output logic [IDX_W-2:0]        pair_index,
	output logic                    last_pair,
	output wht_pkg::wht_ctrl_t      ctrl,
	output logic [IDX_W-1:0]        fill_idx,
	output logic [IDX_W-1:0]        rd_a,
	output logic [IDX_W-1:0]        rd_b,
	output logic [IDX_W-1:0]        a_idx,
	output logic [IDX_W-1:0]        b_idx
);
	import wht_pkg::*;

	localparam int SW = (IDX_W > 1) ? $clog2(IDX_W) : 1;

	wht_state_t       state_q, state_d;
	logic [IDX_W-1:0] fill_q;
	logic [SW-1:0]    stage_q;
	logic [IDX_W-2:0] bfly_q;
	logic [IDX_W-2:0] k_rd;
	logic [IDX_W-1:0] lo, hi, xa;
	logic [IDX_W-1:0] a_idx_s1, b_idx_s1;
	logic             bfly_v_s1;
	logic             pair_valid_q;
	logic [IDX_W-2:0] pair_index_q;
	logic             last_pair_q;
	logic             adv;
	logic             rd_issue;
	logic             k_last;

	assign adv    = !pair_valid_q || !pair_stall;
	assign k_last = (bfly_q == '1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (sample_valid && fill_q == '1) state_d = ST_XFORM;
			end
			ST_XFORM: begin
				if (k_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = (stage_q == SW'(IDX_W - 1)) ? ST_EMIT_RD : ST_XFORM;
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_MUL;
			end
			ST_EMIT_MUL: begin
				state_d = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				if (adv) state_d = k_last ? ST_LOAD : ST_EMIT_MUL;
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_comb begin
		lo = {1'b0, bfly_q};
		hi = {bfly_q, 1'b0};
		for (int p = 0; p < IDX_W; p++) begin
			if (p < int'(stage_q)) xa[p] = lo[p];
			else if (p == int'(stage_q)) xa[p] = 1'b0;
			else xa[p] = hi[p];
		end
	end

	always_comb begin
		sample_stall  = 1'b1;
		ctrl          = '0;
		rd_issue      = 1'b0;
		k_rd          = bfly_q;
		rd_a          = xa;
		rd_b          = xa | (IDX_W'(1) << stage_q);
		case (state_q)
			ST_LOAD: begin
				sample_stall = 1'b0;
				ctrl.load_wr = sample_valid;
			end
			ST_XFORM: begin
				rd_issue = 1'b1;
			end
			ST_DRAIN: begin
				rd_issue = 1'b0;
			end
			ST_EMIT_RD: begin
				rd_issue = 1'b1;
				rd_a     = {k_rd, 1'b0};
				rd_b     = {k_rd, 1'b1};
			end
			ST_EMIT_MUL: begin
				ctrl.mul_en = 1'b1;
			end
			ST_EMIT_OUT: begin
				ctrl.out_load = adv;
				rd_issue      = adv && !k_last;
				k_rd          = bfly_q + 1'b1;
				rd_a          = {k_rd, 1'b0};
				rd_b          = {k_rd, 1'b1};
			end
			default: begin
				sample_stall = 1'b1;
			end
		endcase
		ctrl.bfly_wr = bfly_v_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			fill_q       <= '0;
			stage_q      <= '0;
			bfly_q       <= '0;
			bfly_v_s1    <= 1'b0;
			pair_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			bfly_v_s1 <= (state_q == ST_XFORM);
			if (ctrl.load_wr) begin
				fill_q <= fill_q + 1'b1;
			end
			if (state_q == ST_XFORM) begin
				bfly_q <= bfly_q + 1'b1;
			end
			if (state_q == ST_DRAIN) begin
				stage_q <= (stage_q == SW'(IDX_W - 1)) ? '0 : stage_q + 1'b1;
			end
			if (ctrl.out_load) begin
				bfly_q <= bfly_q + 1'b1;
			end
			if (ctrl.out_load) begin
				pair_valid_q <= 1'b1;
			end else if (!pair_stall) begin
				pair_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			a_idx_s1 <= rd_a;
			b_idx_s1 <= rd_b;
		end
		if (ctrl.out_load) begin
			pair_index_q <= bfly_q;
			last_pair_q  <= k_last;
		end
	end

	assign fill_idx   = fill_q;
	assign a_idx      = a_idx_s1;
	assign b_idx      = b_idx_s1;
	assign pair_valid = pair_valid_q;
	assign pair_index = pair_index_q;
	assign last_pair  = last_pair_q;

	`WHT_ASSERT_NOW(a_bfly_src, bfly_v_s1, $past(state_q == ST_XFORM), "writeback without read")
	`WHT_ASSERT_NOW(a_out_free, ctrl.out_load, !pair_valid_q || !pair_stall, "output overwritten")
	`WHT_ASSERT_NOW(a_fill_idle, state_q != ST_LOAD, fill_q == '0, "fill count set outside load")
	`WHT_ASSERT_NEXT(a_last_mark, ctrl.out_load && k_last, last_pair_q && pair_valid_q, "last item unmarked")

endmodule
